[src/chws_pkg.sv]
package chws_pkg;

   typedef struct packed {
      logic       opcode;
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [1:0]  status;
      logic [12:0] stored_words;
   } rsp_type;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_POOL_FULL = 2'd1;
   localparam logic [1:0] ST_TOO_LONG = 2'd2;

   typedef enum logic [3:0] {
      S_COLLECT,
      S_HASH,
      S_HEAD_RD,
      S_HEAD_WAIT,
      S_INS_COPY,
      S_LINK_RD,
      S_LINK_WAIT,
      S_CMP,
      S_CMP_WAIT,
      S_RESULT
   } state_type;

   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7a) begin
         return c - 8'd32;
      end
      return c;
   endfunction

endpackage

[src/chws_ctrl.sv]
// Word collection, hashing and chain walk sequencer with the pool memories.
module chws_ctrl #(
   parameter int BUCKETS    = 260,
   parameter int MAX_WORD   = 45,
   parameter int POOL_WORDS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  chws_pkg::req_type req_data,
   output logic              res_valid,
   input  logic              res_ready,
   output chws_pkg::rsp_type res_data
);
   localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int CW  = $clog2(MAX_WORD + 1);
   localparam int IW  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int PW  = $clog2(POOL_WORDS + 1);
   localparam int EW  = $clog2(POOL_WORDS);
   localparam int AW  = $clog2(POOL_WORDS * MAX_WORD);
   localparam int SW  = 14;

   // memories
   logic [PW-1:0] head_mem [BUCKETS];
   logic [BUCKETS-1:0] head_vld_ff;
   logic [7:0]    char_mem [POOL_WORDS*MAX_WORD];
   logic [CW-1:0] len_mem  [POOL_WORDS];
   logic [PW-1:0] link_mem [POOL_WORDS];
   logic [7:0]    wbuf_ff  [MAX_WORD];

   chws_pkg::state_type state_ff, state_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          ovl_ff, ovl_in;
   logic          op_ff, op_in;
   logic [BW-1:0] bkt_ff, bkt_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [PW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] ci_ff, ci_in;
   logic          found_ff, found_in;
   logic [1:0]    stat_ff, stat_in;
   logic [PW-1:0] head_q, link_q;
   logic [CW-1:0] len_q;
   logic [7:0]    char_q;
   logic [7:0]    wchar_ff;
   logic          head_v_ff;
   logic [PW-1:0] steps_ff, steps_in;

   logic accept;
   assign accept = req_valid && req_ready;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         chws_pkg::S_COLLECT: begin
            if (accept && req_data.last_char) begin
               state_in = chws_pkg::S_HASH;
            end
         end
         chws_pkg::S_HASH: begin
            if (rem_ff < SW'(BUCKETS)) begin
               if (ovl_ff) state_in = chws_pkg::S_RESULT;
               else if (op_ff == chws_pkg::OP_INSERT && cnt_ff >= PW'(POOL_WORDS))
                  state_in = chws_pkg::S_RESULT;
               else if (op_ff == chws_pkg::OP_INSERT) state_in = chws_pkg::S_INS_COPY;
               else state_in = chws_pkg::S_HEAD_RD;
            end
         end
         chws_pkg::S_INS_COPY: begin
            if (ci_ff + CW'(1) >= idx_ff) state_in = chws_pkg::S_HEAD_RD;
         end
         chws_pkg::S_HEAD_RD:   state_in = chws_pkg::S_HEAD_WAIT;
         chws_pkg::S_HEAD_WAIT: begin
            if (op_ff == chws_pkg::OP_INSERT) state_in = chws_pkg::S_RESULT;
            else if (!head_v_ff || head_q == '0) state_in = chws_pkg::S_RESULT;
            else state_in = chws_pkg::S_LINK_RD;
         end
         chws_pkg::S_LINK_RD:   state_in = chws_pkg::S_LINK_WAIT;
         chws_pkg::S_LINK_WAIT: begin
            if (len_q != idx_ff) state_in = chws_pkg::S_LINK_RD;
            else state_in = chws_pkg::S_CMP;
         end
         chws_pkg::S_CMP:       state_in = chws_pkg::S_CMP_WAIT;
         chws_pkg::S_CMP_WAIT: begin
            if (chws_pkg::fold_upper(char_q) != chws_pkg::fold_upper(wchar_ff))
               state_in = chws_pkg::S_LINK_RD;
            else if (ci_ff + CW'(1) >= idx_ff) state_in = chws_pkg::S_RESULT;
            else state_in = chws_pkg::S_CMP;
         end
         chws_pkg::S_RESULT: begin
            if (res_ready) state_in = chws_pkg::S_COLLECT;
         end
         default: state_in = chws_pkg::S_COLLECT;
      endcase
      // chain end or walk step limit reached while walking
      if ((state_ff == chws_pkg::S_LINK_WAIT || state_ff == chws_pkg::S_CMP_WAIT)
          && state_in == chws_pkg::S_LINK_RD
          && (link_q == '0 || steps_ff + PW'(1) >= PW'(POOL_WORDS))) begin
         state_in = chws_pkg::S_RESULT;
      end
   end

   // datapath next values
   always_comb begin
      logic [SW-1:0] sum_a;
      sum_a    = sum_ff + SW'(chws_pkg::fold_upper(req_data.char_code));
      sum_in   = sum_ff;
      idx_in   = idx_ff;
      ovl_in   = ovl_ff;
      op_in    = op_ff;
      bkt_in   = bkt_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      ptr_in   = ptr_ff;
      ci_in    = ci_ff;
      found_in = found_ff;
      stat_in  = stat_ff;
      steps_in = steps_ff;
      unique case (state_ff)
         chws_pkg::S_COLLECT: begin
            if (accept) begin
               op_in = req_data.opcode;
               if (!ovl_ff) begin
                  if (idx_ff < CW'(MAX_WORD)) begin
                     idx_in = idx_ff + CW'(1);
                     sum_in = sum_a;
                  end else begin
                     ovl_in = 1'b1;
                  end
               end
               rem_in   = sum_in;
               found_in = 1'b0;
               stat_in  = chws_pkg::ST_OK;
               ci_in    = '0;
               steps_in = '0;
            end
         end
         chws_pkg::S_HASH: begin
            // subtract one modulus per cycle
            if (rem_ff >= SW'(BUCKETS)) rem_in = rem_ff - SW'(BUCKETS);
            else begin
               bkt_in = BW'(rem_ff);
               if (ovl_ff) stat_in = chws_pkg::ST_TOO_LONG;
               else if (op_ff == chws_pkg::OP_INSERT && cnt_ff >= PW'(POOL_WORDS))
                  stat_in = chws_pkg::ST_POOL_FULL;
            end
         end
         chws_pkg::S_INS_COPY: ci_in = ci_ff + CW'(1);
         chws_pkg::S_HEAD_WAIT: begin
            ci_in = '0;
            if (op_ff == chws_pkg::OP_INSERT) cnt_in = cnt_ff + PW'(1);
            else ptr_in = head_v_ff ? head_q : '0;
         end
         chws_pkg::S_LINK_WAIT: begin
            ci_in = '0;
            if (len_q != idx_ff) begin
               ptr_in = link_q;
               steps_in = steps_ff + PW'(1);
            end
         end
         chws_pkg::S_CMP_WAIT: begin
            if (chws_pkg::fold_upper(char_q) != chws_pkg::fold_upper(wchar_ff))
            begin
               ptr_in = link_q;
               steps_in = steps_ff + PW'(1);
               ci_in = '0;
            end else if (ci_ff + CW'(1) >= idx_ff) found_in = 1'b1;
            else ci_in = ci_ff + CW'(1);
         end
         chws_pkg::S_RESULT: begin
            if (res_ready) begin
               sum_in = '0;
               idx_in = '0;
               ovl_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == chws_pkg::S_COLLECT);
      res_valid = (state_ff == chws_pkg::S_RESULT);
      res_data.found        = found_ff;
      res_data.status       = stat_ff;
      res_data.stored_words = 13'(cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chws_pkg::S_COLLECT;
         sum_ff   <= '0;
         idx_ff   <= '0;
         ovl_ff   <= 1'b0;
         cnt_ff   <= '0;
         found_ff <= 1'b0;
         stat_ff  <= chws_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         idx_ff   <= idx_in;
         ovl_ff   <= ovl_in;
         cnt_ff   <= cnt_in;
         found_ff <= found_in;
         stat_ff  <= stat_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      bkt_ff   <= bkt_in;
      rem_ff   <= rem_in;
      ptr_ff   <= ptr_in;
      ci_ff    <= ci_in;
      steps_ff <= steps_in;
   end

   // word buffer; registered read at the next character index, so wchar_ff matches ci_ff
   always_ff @(posedge clock) begin
      if (accept && !ovl_ff && idx_ff < CW'(MAX_WORD)) begin
         wbuf_ff[idx_ff[IW-1:0]] <= req_data.char_code;
      end
      wchar_ff <= wbuf_ff[ci_in[IW-1:0]];
   end

   // bucket heads with per-bucket valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= '0;
      end else if (state_ff == chws_pkg::S_HEAD_WAIT && op_ff == chws_pkg::OP_INSERT) begin
         head_vld_ff[bkt_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == chws_pkg::S_HEAD_WAIT && op_ff == chws_pkg::OP_INSERT) begin
         head_mem[bkt_ff] <= cnt_ff + PW'(1);
      end
      if (state_ff == chws_pkg::S_HEAD_RD) begin
         head_q    <= head_mem[bkt_ff];
         head_v_ff <= head_vld_ff[bkt_ff];
      end
   end

   // pool memories
   logic [EW-1:0] ent;
   logic [EW-1:0] rd_ent;
   assign ent    = cnt_ff[EW-1:0];
   assign rd_ent = EW'(ptr_ff - PW'(1));

   always_ff @(posedge clock) begin
      if (state_ff == chws_pkg::S_INS_COPY) begin
         char_mem[AW'(ent * MAX_WORD) + AW'(ci_ff)] <= wchar_ff;
      end
      if (state_ff == chws_pkg::S_CMP) begin
         char_q <= char_mem[AW'(rd_ent * MAX_WORD) + AW'(ci_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == chws_pkg::S_HEAD_WAIT && op_ff == chws_pkg::OP_INSERT) begin
         len_mem[ent]  <= idx_ff;
         link_mem[ent] <= head_v_ff ? head_q : '0;
      end
      if (state_ff == chws_pkg::S_LINK_RD) begin
         len_q  <= len_mem[rd_ent];
         link_q <= link_mem[rd_ent];
      end
   end
endmodule

[src/chained_hash_word_set_unit.sv]
// Case-insensitive word set, separately chained buckets.
// Request channel (req_valid/req_ready/req_data): one character per request,
// req_data.last_char marks the end of a word; the opcode of the last request
// selects insert or lookup. Response channel (rsp_valid/rsp_ready/rsp_data):
// exactly one response per completed word with found, status, stored_words.
// Characters are accepted back to back while a word is collected. After the
// last character, the hash modulo is reduced by one subtraction per cycle,
// then an insert copies the word into the pool one byte a cycle and updates
// the bucket head; a lookup reads the bucket head and walks the chain,
// reading each entry's length and link and then comparing its characters
// one at a time, each through the single read port of the pool memories.
// The block handles one word at a time.
// Reset clears the bucket valid bits, the count and word state;
// no clearing pass is needed. When the receiver stalls, the response holds
// and no new request is taken until it is accepted.
module chained_hash_word_set_unit #(
   parameter int BUCKETS    = 260,
   parameter int MAX_WORD   = 45,
   parameter int POOL_WORDS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  chws_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output chws_pkg::rsp_type rsp_data
);
   // sequencer and pool memories
   chws_ctrl #(
      .BUCKETS(BUCKETS), .MAX_WORD(MAX_WORD), .POOL_WORDS(POOL_WORDS)
   ) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .res_valid(rsp_valid), .res_ready(rsp_ready), .res_data(rsp_data)
   );
endmodule

[src/chws_checker.sv]
module chws_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input chws_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input chws_pkg::rsp_type rsp_data
);
   // a response never reports found with a fault status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.found && rsp_data.status != chws_pkg::ST_OK))
      else $error("found with error status");
   // status code stays in range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3)
      else $error("bad status");
   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped");
   // no new request taken while a response waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken during response");
   // stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request dropped");
endmodule

bind chained_hash_word_set_unit chws_checker u_chk (.*);
